// ===== rtl/interleaved_gamma_codec_macros.svh =====
`ifndef INTERLEAVED_GAMMA_CODEC_MACROS_SVH
`define INTERLEAVED_GAMMA_CODEC_MACROS_SVH

// Concurrent assertion on clk_i, disabled while rst_ni is low.
`define IGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent assertion that a condition is never true.
`define IGC_ASSERT_NEVER(lbl, cond, msg) \
  `IGC_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/igc_pkg.sv =====
package igc_pkg;

  localparam int unsigned NUM_W = 32;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam logic [NUM_W-1:0] VALUE_MASK = NUM_W'((64'd1 << VALUE_BITS) - 64'd1);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_CODE   = 2'd0,
    KIND_NUMBER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_ENCODE    = 2'd0,
    OP_ENC_ERROR = 2'd1,
    OP_DECODE    = 2'd2
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [NUM_W-1:0] number;
    logic             code_bit;
  } entry_t;

  typedef struct packed {
    kind_e            kind;
    logic             code_bit;
    logic             last;
    logic [NUM_W-1:0] number;
  } result_t;

endpackage

// ===== rtl/igc_front.sv =====
module igc_front
  import igc_pkg::*;
(
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  input  logic [NUM_W-1:0] number_in_i,
  input  logic             code_bit_in_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output entry_t           q_entry_o
);

  logic enc_bad;

  assign enc_bad = (number_in_i == '0) || ((number_in_i & ~VALUE_MASK) != '0);

  always_comb begin
    q_entry_o.number   = number_in_i;
    q_entry_o.code_bit = code_bit_in_i;
    if (cmd_i) begin
      q_entry_o.op = OP_DECODE;
    end else if (enc_bad) begin
      q_entry_o.op = OP_ENC_ERROR;
    end else begin
      q_entry_o.op = OP_ENCODE;
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

// ===== rtl/igc_queue.sv =====
module igc_queue
  import igc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  input  logic   pop_i,
  output entry_t pop_data_o,
  output logic   full_o,
  output logic   empty_o
);

  entry_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/igc_back.sv =====
`include "interleaved_gamma_codec_macros.svh"

module igc_back
  import igc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  entry_t  q_data_i,
  input  logic    q_empty_i,
  output logic    q_pop_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_o
);

  logic                  out_valid_q, out_valid_d;
  result_t               out_q, out_d;
  logic                  busy_q, busy_d;
  logic                  phase_q, phase_d;
  logic [NUM_W-1:0]      shreg_q, shreg_d;
  logic                  exp_q, exp_d;
  logic [VALUE_BITS-1:0] part_q, part_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  adv;
  logic [NUM_W-1:0]      src;
  logic                  ph;
  logic [VALUE_BITS-1:0] with_one;

  assign adv = !out_valid_q || !out_stall_i;
  assign src = busy_q ? shreg_q : q_data_i.number;
  assign ph  = busy_q && phase_q;

  always_comb begin
    for (int i = 0; i < VALUE_BITS; i++) begin
      with_one[i] = part_q[i] || (cnt_q == CNT_W'(i));
    end
  end

  always_comb begin
    q_pop_o     = 1'b0;
    out_valid_d = adv ? 1'b0 : out_valid_q;
    out_d       = out_q;
    busy_d      = busy_q;
    phase_d     = phase_q;
    shreg_d     = shreg_q;
    exp_d       = exp_q;
    part_d      = part_q;
    cnt_d       = cnt_q;
    if (adv && (busy_q || !q_empty_i)) begin
      if (!busy_q) begin
        q_pop_o = 1'b1;
      end
      if (busy_q || (q_data_i.op == OP_ENCODE)) begin
        out_valid_d     = 1'b1;
        out_d.kind      = KIND_CODE;
        out_d.number    = '0;
        if (ph) begin
          out_d.code_bit = src[0];
          out_d.last     = 1'b0;
          shreg_d        = src >> 1;
          phase_d        = 1'b0;
          busy_d         = 1'b1;
        end else if (|src[NUM_W-1:1]) begin
          out_d.code_bit = 1'b0;
          out_d.last     = 1'b0;
          shreg_d        = src;
          phase_d        = 1'b1;
          busy_d         = 1'b1;
        end else begin
          out_d.code_bit = 1'b1;
          out_d.last     = 1'b1;
          phase_d        = 1'b0;
          busy_d         = 1'b0;
        end
      end else begin
        unique case (q_data_i.op)
          OP_ENC_ERROR: begin
            out_valid_d = 1'b1;
            out_d       = '{kind: KIND_ERROR, code_bit: 1'b0, last: 1'b1, number: '0};
          end
          OP_DECODE: begin
            if (exp_q) begin
              if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
                exp_d       = 1'b0;
                part_d      = '0;
                cnt_d       = '0;
                out_valid_d = 1'b1;
                out_d       = '{kind: KIND_ERROR, code_bit: 1'b0, last: 1'b1, number: '0};
              end else begin
                part_d[cnt_q] = q_data_i.code_bit;
                cnt_d         = cnt_q + CNT_W'(1);
                exp_d         = 1'b0;
              end
            end else if (!q_data_i.code_bit) begin
              exp_d = 1'b1;
            end else begin
              exp_d       = 1'b0;
              part_d      = '0;
              cnt_d       = '0;
              out_valid_d = 1'b1;
              out_d       = '{kind: KIND_NUMBER, code_bit: 1'b0, last: 1'b1,
                              number: NUM_W'(with_one)};
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      phase_q     <= 1'b0;
      exp_q       <= 1'b0;
      part_q      <= '0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      busy_q      <= busy_d;
      phase_q     <= phase_d;
      exp_q       <= exp_d;
      part_q      <= part_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    shreg_q <= shreg_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `IGC_ASSERT(a_busy_nonzero, busy_q |-> (shreg_q != '0), "encoder busy with empty shift register")
  `IGC_ASSERT_NEVER(a_pop_busy, q_pop_o && busy_q, "queue popped during an encode")
  `IGC_ASSERT_NEVER(a_phase_idle, phase_q && !busy_q, "data phase without an encode")
  `IGC_ASSERT(a_cnt_range, cnt_q <= CNT_W'(VALUE_BITS - 1), "data bit count out of range")

endmodule

// ===== rtl/interleaved_gamma_codec.sv =====
// Interleaved Elias gamma encoder and decoder. Each input item is either an encode
// (cmd_i low) or one code bit to decode (cmd_i high). Items pass through a two-entry
// queue to an execution unit that produces at most one result item per cycle into an
// output register. A decode item gives a result only when it ends a number or overflows.
// An encode of a number whose leading one sits at bit t emits 2t+1 code bits, one per
// cycle while the output is not stalled, with the last one marked; encoding zero gives a
// single error result. The encode sequencer, a shift register shifted once per data bit,
// sets the rate. Encoding does not disturb a decode in progress.
module interleaved_gamma_codec
  import igc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  input  logic [NUM_W-1:0] number_in_i,
  input  logic             code_bit_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       kind_o,
  output logic             code_bit_out_o,
  output logic             last_o,
  output logic [NUM_W-1:0] number_out_o
);

  entry_t  push_entry, pop_entry;
  logic    push, pop, full, empty;
  result_t res;

  igc_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .number_in_i   (number_in_i),
    .code_bit_in_i (code_bit_in_i),
    .q_full_i      (full),
    .q_push_o      (push),
    .q_entry_o     (push_entry)
  );

  igc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .pop_data_o  (pop_entry),
    .full_o      (full),
    .empty_o     (empty)
  );

  igc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_data_i    (pop_entry),
    .q_empty_i   (empty),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res)
  );

  assign kind_o         = res.kind;
  assign code_bit_out_o = res.code_bit;
  assign last_o         = res.last;
  assign number_out_o   = res.number;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench
  import igc_pkg::*;
();

  typedef struct {
    kind_e            kind;
    logic             code_bit;
    logic             last;
    logic [NUM_W-1:0] number;
  } gamma_result_t;

  // Tracks the decoder state and the results still owed by the block.
  class gamma_board;
    gamma_result_t    awaited[$];
    logic             holding_data;
    logic [NUM_W-1:0] gathered;
    int unsigned      gathered_bits;
    int               failures;
    int               results_seen;
    int               numbers_seen;
    int               errors_seen;

    function new();
      holding_data = 1'b0;
      gathered = '0;
      gathered_bits = 0;
      failures = 0;
      results_seen = 0;
      numbers_seen = 0;
      errors_seen = 0;
    endfunction

    function void owe(kind_e kind, logic code_bit, logic last, logic [NUM_W-1:0] number);
      gamma_result_t r;
      r.kind = kind;
      r.code_bit = code_bit;
      r.last = last;
      r.number = number;
      awaited.insert(awaited.size(), r);
    endfunction

    function void clear_decoder();
      holding_data = 1'b0;
      gathered = '0;
      gathered_bits = 0;
    endfunction

    function void note_item(logic cmd, logic [NUM_W-1:0] value, logic code_bit);
      int unsigned top;
      if (cmd == 1'b0) begin
        if (value == '0 || (value & ~VALUE_MASK) != '0) begin
          owe(KIND_ERROR, 1'b0, 1'b1, '0);
        end else begin
          top = 0;
          for (int i = 0; i < NUM_W; i++) begin
            if (value[i]) begin
              top = i;
            end
          end
          for (int i = 0; i < top; i++) begin
            owe(KIND_CODE, 1'b0, 1'b0, '0);
            owe(KIND_CODE, value[i], 1'b0, '0);
          end
          owe(KIND_CODE, 1'b1, 1'b1, '0);
        end
      end else if (holding_data) begin
        if (gathered_bits >= VALUE_BITS - 1) begin
          clear_decoder();
          owe(KIND_ERROR, 1'b0, 1'b1, '0);
        end else begin
          gathered[gathered_bits] = code_bit;
          gathered_bits++;
          holding_data = 1'b0;
        end
      end else if (!code_bit) begin
        holding_data = 1'b1;
      end else begin
        owe(KIND_NUMBER, 1'b0, 1'b1, gathered | (NUM_W'(1) << gathered_bits));
        clear_decoder();
      end
    endfunction

    function void report(string field, logic [NUM_W-1:0] want, logic [NUM_W-1:0] got);
      $display("%0t: wrong %s, expected %0h, actual %0h", $time, field, want, got);
      failures++;
    endfunction

    function void check_result(logic [1:0] kind, logic code_bit, logic last,
                               logic [NUM_W-1:0] number);
      gamma_result_t want;
      results_seen++;
      if (kind == KIND_NUMBER) begin
        numbers_seen++;
      end
      if (kind == KIND_ERROR) begin
        errors_seen++;
      end
      if (awaited.size() == 0) begin
        $display("%0t: expected no result, actual kind %0d bit %0b last %0b num %0h",
                 $time, kind, code_bit, last, number);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (kind !== want.kind) begin
        report("kind", NUM_W'(want.kind), NUM_W'(kind));
      end
      if (code_bit !== want.code_bit) begin
        report("code bit", NUM_W'(want.code_bit), NUM_W'(code_bit));
      end
      if (last !== want.last) begin
        report("last flag", NUM_W'(want.last), NUM_W'(last));
      end
      if (number !== want.number) begin
        report("number", want.number, number);
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             cmd_i = 1'b0;
  logic [NUM_W-1:0] number_in_i = '0;
  logic             code_bit_in_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [1:0]       kind_o;
  logic             code_bit_out_o;
  logic             last_o;
  logic [NUM_W-1:0] number_out_o;

  gamma_board board = new();
  int         items_sent = 0;
  int         encodes = 0;
  int         decodes = 0;
  int         idle_odds = 0;
  logic       quiet = 1'b0;

  interleaved_gamma_codec DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .number_in_i    (number_in_i),
    .code_bit_in_i  (code_bit_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .code_bit_out_o (code_bit_out_o),
    .last_o         (last_o),
    .number_out_o   (number_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        board.note_item(cmd_i, number_in_i, code_bit_in_i);
      end
      if (out_valid_o && !out_stall_i) begin
        board.check_result(kind_o, code_bit_out_o, last_o, number_out_o);
      end
    end
  end

  initial begin
    int stall_left;
    int sink_odds;
    int cycle_no;
    stall_left = 0;
    sink_odds = 0;
    cycle_no = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cycle_no++;
      if (cycle_no % 64 == 0) begin
        sink_odds = $urandom_range(0, 2) * 3;
      end
      if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else if (!quiet && sink_odds != 0 && $urandom_range(0, sink_odds) == 0) begin
        out_stall_i = 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(logic cmd, logic [NUM_W-1:0] value, logic code_bit);
    quiet = (items_sent >= 370);
    if (!quiet && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i = cmd;
    number_in_i = value;
    code_bit_in_i = code_bit;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (cmd) begin
      decodes++;
    end else begin
      encodes++;
    end
    @(negedge clk_i);
  endtask

  task automatic encode_value(logic [NUM_W-1:0] value);
    send_item(1'b0, value, 1'($urandom_range(0, 1)));
  endtask

  task automatic feed_code_bit(logic code_bit);
    send_item(1'b1, $urandom(), code_bit);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (board.awaited.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  function automatic logic [NUM_W-1:0] rand_value();
    int unsigned      top;
    logic [NUM_W-1:0] low_mask;
    if ($urandom_range(0, 9) < 7) begin
      top = $urandom_range(0, 7);
    end else begin
      top = $urandom_range(8, NUM_W - 1);
    end
    low_mask = (NUM_W'(1) << top) - NUM_W'(1);
    return ($urandom() & low_mask) | (NUM_W'(1) << top);
  endfunction

  // Feeds the code of one number, LSB first, sometimes with encodes mixed in.
  task automatic decode_stream(logic [NUM_W-1:0] value, logic mix);
    int unsigned top;
    top = 0;
    for (int i = 0; i < NUM_W; i++) begin
      if (value[i]) begin
        top = i;
      end
    end
    for (int i = 0; i < top; i++) begin
      feed_code_bit(1'b0);
      if (mix && $urandom_range(0, 4) == 0) begin
        encode_value(rand_value());
      end
      feed_code_bit(value[i]);
    end
    feed_code_bit(1'b1);
  endtask

  task automatic overflow_run();
    for (int i = 0; i < VALUE_BITS - 1; i++) begin
      feed_code_bit(1'b0);
      feed_code_bit(1'($urandom_range(0, 1)));
    end
    feed_code_bit(1'b0);
    feed_code_bit(1'($urandom_range(0, 1)));
  endtask

  initial begin
    int   pick;
    logic paused;
    paused = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    encode_value('0);
    encode_value(32'h0000_0001);
    encode_value(32'hFFFF_FFFF);
    encode_value(32'h8000_0000);
    encode_value(32'h0000_0006);
    encode_value(32'h7FFF_FFFF);
    feed_code_bit(1'b1);
    feed_code_bit(1'b0);
    feed_code_bit(1'b1);
    encode_value(32'h0000_0005);
    feed_code_bit(1'b0);
    feed_code_bit(1'b0);
    feed_code_bit(1'b1);
    feed_code_bit(1'b0);
    feed_code_bit(1'b0);
    feed_code_bit(1'b1);

    while (items_sent < 410) begin
      idle_odds = ($urandom_range(0, 3) == 0) ? 0 : 3;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        encode_value(($urandom_range(0, 19) == 0) ? '0 : rand_value());
      end else if (pick < 75) begin
        decode_stream(rand_value(), pick < 45);
      end else if (pick < 83) begin
        overflow_run();
      end else begin
        repeat ($urandom_range(1, 6)) feed_code_bit(1'($urandom_range(0, 1)));
      end
      if (!paused && items_sent >= 200) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    $display("Checked %0d results from %0d items: %0d encodes and %0d decode bits.",
             board.results_seen, items_sent, encodes, decodes);
    $display("The block returned %0d decoded numbers and %0d errors.",
             board.numbers_seen, board.errors_seen);
    if (board.failures == 0) begin
      $display("interleaved_gamma_codec: match");
    end else begin
      $display("interleaved_gamma_codec: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", board.awaited.size());
    $display("interleaved_gamma_codec: mismatch");
    $finish;
  end

endmodule
